[src/wag_pkg.sv]
// ----------------------------------------------------------------------------
// Wind average and gust package
// Shared widths, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
package wag_pkg;

    localparam int PULSE_W  = 15;
    localparam int FACTOR_W = 16;
    localparam int SPEED_W  = 31;

    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd614;

    localparam int AVG_DEPTH_DEF = 60;
    localparam int GUST_LEN_DEF  = 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_RDH,
        S_ADDH,
        S_SUBT,
        S_CMP,
        S_DIVA,
        S_WAITA,
        S_DIVG,
        S_WAITG,
        S_OUT
    } state_t;

endpackage

[src/wag_div.sv]
// ----------------------------------------------------------------------------
// Serial unsigned divider
// Restoring division, one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module wag_div
    import wag_pkg::*;
#(
    parameter int DW = 39,
    parameter int VW = 9
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CNW = $clog2(DW + 1);

    logic [DW-1:0]  work_reg, work_next;
    logic [VW-1:0]  rem_reg, rem_next;
    logic [VW-1:0]  dvs_reg, dvs_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [VW:0]    trial;
    logic           fits;

    assign trial = {rem_reg, work_reg[DW-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            work_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            work_next = {work_reg[DW-2:0], fits};
            rem_next  = fits ? VW'(trial - {1'b0, dvs_reg}) : VW'(trial);
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNW'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

[src/wind_average_and_gust_unit.sv]
// ----------------------------------------------------------------------------
// Wind average and gust unit
// Scales a pulse count to a speed, keeps a ring of recent speeds and reports
// the window average and the largest gust-length run mean.
// ----------------------------------------------------------------------------
// The input stalls from each accepted sample until the result has been
// taken. The ring walk visits the N stored samples in turn, adding each to
// the total and the run window and, past the first GUST_LEN, subtracting
// the leaving sample in a step of its own, since the single ring read port
// serves both the newest and the leaving sample of the run window. The
// serial divider then computes the average, and the gust too when N reaches
// GUST_LEN; DW is 31 plus the ceiling log2 of the larger parameter, so DW
// is 37 at the defaults, where the ring holds 60 samples and GUST_LEN is 1.
module wind_average_and_gust_unit
    import wag_pkg::*;
#(
    parameter int AVG_DEPTH = AVG_DEPTH_DEF,
    parameter int GUST_LEN  = GUST_LEN_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [FACTOR_W-1:0] cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [PULSE_W-1:0]  anemo_pulses,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SPEED_W-1:0]  instant_speed,
    output logic [SPEED_W-1:0]  average_speed,
    output logic [SPEED_W-1:0]  gust_speed
);

    localparam int AW   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int CW   = $clog2(AVG_DEPTH + 1);
    localparam int MAXP = (AVG_DEPTH > GUST_LEN) ? AVG_DEPTH : GUST_LEN;
    localparam int DW   = SPEED_W + $clog2(MAXP);
    localparam int VW   = $clog2(MAXP + 1);

    state_t state_reg, state_next;

    logic [FACTOR_W-1:0] factor_reg;
    logic [SPEED_W-1:0]  speed_reg, speed_next;
    logic [SPEED_W-1:0]  avg_reg, avg_next;
    logic [SPEED_W-1:0]  gust_reg, gust_next;
    logic [AW-1:0]       wslot_reg, wslot_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [AW-1:0]       tail_reg, tail_next;
    logic [CW-1:0]       pos_reg, pos_next;
    logic [DW-1:0]       total_reg, total_next;
    logic [DW-1:0]       win_reg, win_next;
    logic [DW-1:0]       max_reg, max_next;

    logic [SPEED_W-1:0]  ring_mem [AVG_DEPTH];
    logic [SPEED_W-1:0]  rdata_reg;
    logic                mem_we;
    logic [AW-1:0]       raddr;

    logic                div_start;
    logic [DW-1:0]       div_dividend;
    logic [VW-1:0]       div_divisor;
    logic                div_done;
    logic [DW-1:0]       div_quotient;

    logic                in_fire;
    logic                last_pos;
    logic                gust_ready;

    assign in_fire    = in_valid && !in_stall;
    assign last_pos   = (CW'(pos_reg + 1'b1) == count_reg);
    assign gust_ready = (int'(count_reg) >= GUST_LEN);

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] ptr);
        wrap_inc = (ptr == AW'(AVG_DEPTH - 1)) ? '0 : AW'(ptr + 1'b1);
    endfunction

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_fire) state_next = S_WRITE;
            S_WRITE: state_next = S_RDH;
            S_RDH:   state_next = S_ADDH;
            S_ADDH:  state_next = (int'(pos_reg) >= GUST_LEN) ? S_SUBT : S_CMP;
            S_SUBT:  state_next = S_CMP;
            S_CMP:   state_next = last_pos ? S_DIVA : S_ADDH;
            S_DIVA:  state_next = S_WAITA;
            S_WAITA:
            begin
                if (div_done)
                begin
                    state_next = gust_ready ? S_DIVG : S_OUT;
                end
            end
            S_DIVG:  state_next = S_WAITG;
            S_WAITG: if (div_done) state_next = S_OUT;
            S_OUT:   if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall     = (state_reg != S_IDLE);
        out_valid    = (state_reg == S_OUT);
        cfg_ready    = 1'b1;
        mem_we       = (state_reg == S_WRITE);
        raddr        = (state_reg == S_ADDH) ? tail_reg : head_reg;
        div_start    = (state_reg == S_DIVA) || (state_reg == S_DIVG);
        div_dividend = (state_reg == S_DIVA) ? total_reg : max_reg;
        div_divisor  = (state_reg == S_DIVA) ? VW'(count_reg) : VW'(GUST_LEN);
    end

    always_comb
    begin
        speed_next = speed_reg;
        avg_next   = avg_reg;
        gust_next  = gust_reg;
        wslot_next = wslot_reg;
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        pos_next   = pos_reg;
        total_next = total_reg;
        win_next   = win_reg;
        max_next   = max_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    speed_next = SPEED_W'(anemo_pulses) * SPEED_W'(factor_reg);
                end
            end
            S_WRITE:
            begin
                wslot_next = wrap_inc(wslot_reg);
                if (count_reg != CW'(AVG_DEPTH))
                begin
                    count_next = CW'(count_reg + 1'b1);
                end
                if (count_next == CW'(AVG_DEPTH))
                begin
                    head_next = wslot_next;
                end
                else
                begin
                    head_next = '0;
                end
                tail_next  = head_next;
                pos_next   = '0;
                total_next = '0;
                win_next   = '0;
                max_next   = '0;
            end
            S_ADDH:
            begin
                total_next = total_reg + DW'(rdata_reg);
                win_next   = win_reg + DW'(rdata_reg);
                head_next  = wrap_inc(head_reg);
            end
            S_SUBT:
            begin
                win_next  = win_reg - DW'(rdata_reg);
                tail_next = wrap_inc(tail_reg);
            end
            S_CMP:
            begin
                if ((int'(pos_reg) + 1 >= GUST_LEN) && (win_reg > max_reg))
                begin
                    max_next = win_reg;
                end
                pos_next = CW'(pos_reg + 1'b1);
            end
            S_WAITA:
            begin
                if (div_done)
                begin
                    avg_next = div_quotient[SPEED_W-1:0];
                    if (!gust_ready)
                    begin
                        gust_next = speed_reg;
                    end
                end
            end
            S_WAITG:
            begin
                if (div_done)
                begin
                    gust_next = div_quotient[SPEED_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            factor_reg <= FACTOR_RESET;
            wslot_reg  <= '0;
            count_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                factor_reg <= cfg_data;
            end
            wslot_reg <= wslot_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        speed_reg <= speed_next;
        avg_reg   <= avg_next;
        gust_reg  <= gust_next;
        head_reg  <= head_next;
        tail_reg  <= tail_next;
        pos_reg   <= pos_next;
        total_reg <= total_next;
        win_reg   <= win_next;
        max_reg   <= max_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[wslot_reg] <= speed_reg;
        end
        rdata_reg <= ring_mem[raddr];
    end

    wag_div #(
        .DW(DW),
        .VW(VW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign instant_speed = speed_reg;
    assign average_speed = avg_reg;
    assign gust_speed    = gust_reg;

endmodule

[src/wag_checker.sv]
// ----------------------------------------------------------------------------
// Wind average and gust port checker
// Watches the top-level ports over time and flags sequencing slips.
// ----------------------------------------------------------------------------
module wag_checker
    import wag_pkg::*;
#(
    parameter int GUST_LEN = GUST_LEN_DEF
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic [SPEED_W-1:0]  instant_speed,
    input logic [SPEED_W-1:0]  average_speed,
    input logic [SPEED_W-1:0]  gust_speed
);

    a_no_input_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("Input accepted while a result transaction is pending.");

    a_no_result_after_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !out_valid)
        else $error("Result appeared one cycle after an input transaction.");

    a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> !out_valid)
        else $error("Result transaction repeated.");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(average_speed)
            && $stable(gust_speed) && $stable(instant_speed)))
        else $error("Stalled result changed.");

    a_gust_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (GUST_LEN == 1)) |->
            ((gust_speed >= instant_speed) && (gust_speed >= average_speed)))
        else $error("Gust below the instant or average speed.");

endmodule

bind wind_average_and_gust_unit wag_checker #(.GUST_LEN(GUST_LEN)) u_wag_checker (.*);
